FILE: sv/q16_16_fixed_point_alu_assert.svh
// Assertion macros for the Q16.16 arithmetic unit.
`ifndef Q16_16_FIXED_POINT_ALU_ASSERT_SVH
`define Q16_16_FIXED_POINT_ALU_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define QFA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define QFA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/qfa_pkg.sv
package qfa_pkg;

	localparam int DATA_W    = 32;
	localparam int FRAC_BITS = 16;
	localparam int NUM_W     = DATA_W + FRAC_BITS;
	localparam int DIV_STEPS = NUM_W;
	localparam int Q_DEPTH   = 4;
	localparam int Q_AW      = $clog2(Q_DEPTH);

	typedef enum logic [2:0] {
		OP_ADD   = 3'd0,
		OP_SUB   = 3'd1,
		OP_MUL   = 3'd2,
		OP_DIV   = 3'd3,
		OP_EQ    = 3'd4,
		OP_LT    = 3'd5,
		OP_FLOOR = 3'd6,
		OP_FRAC  = 3'd7
	} op_t;

	// One classified item as it waits in the queue.
	typedef struct packed {
		op_t               op;
		logic [DATA_W-1:0] lhs;
		logic [DATA_W-1:0] rhs;
		logic [NUM_W-1:0]  num_mag;
		logic [DATA_W-1:0] den_mag;
		logic              q_neg;
		logic              dz;
	} item_t;

	// One item inside the execution pipeline.
	typedef struct packed {
		logic              is_div;
		logic              q_neg;
		logic              dz;
		logic              flag;
		logic [DATA_W-1:0] res;
		logic [DATA_W-1:0] rem;
		logic [NUM_W-1:0]  num;
		logic [DATA_W-1:0] den;
	} stage_t;

	// One restoring division step: the quotient bit shifts into num.
	function automatic stage_t div_step(input stage_t st);
		stage_t          o;
		logic [DATA_W:0] trial;
		logic            qbit;
		o     = st;
		trial = {st.rem, st.num[NUM_W-1]};
		qbit  = (trial >= {1'b0, st.den});
		if (qbit) begin
			trial = trial - {1'b0, st.den};
		end
		o.rem = trial[DATA_W-1:0];
		o.num = {st.num[NUM_W-2:0], qbit};
		return o;
	endfunction

endpackage

FILE: sv/qfa_front.sv
module qfa_front (
	input  logic [2:0]              kind,
	input  logic signed [31:0]      lhs,
	input  logic signed [31:0]      rhs,
	output qfa_pkg::item_t          item
);

	logic [qfa_pkg::DATA_W-1:0] a_mag;
	logic [qfa_pkg::DATA_W-1:0] b_mag;

	// Split operands into sign and magnitude for the divider.
	always_comb begin
		a_mag = lhs[31] ? (~lhs + 32'd1) : lhs;
		b_mag = rhs[31] ? (~rhs + 32'd1) : rhs;
		item.op      = qfa_pkg::op_t'(kind);
		item.lhs     = lhs;
		item.rhs     = rhs;
		item.num_mag = {a_mag, {qfa_pkg::FRAC_BITS{1'b0}}};
		item.den_mag = b_mag;
		item.q_neg   = lhs[31] ^ rhs[31];
		item.dz      = (rhs == 32'sd0);
	end

endmodule

FILE: sv/qfa_queue.sv
module qfa_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  qfa_pkg::item_t wr_item,
	output logic           full,
	input  logic           pop,
	output qfa_pkg::item_t rd_item,
	output logic           empty
);

	qfa_pkg::item_t             mem_q [qfa_pkg::Q_DEPTH];
	logic [qfa_pkg::Q_AW-1:0]   wr_ptr_q;
	logic [qfa_pkg::Q_AW-1:0]   rd_ptr_q;
	logic [qfa_pkg::Q_AW:0]     count_q;

	assign full    = (count_q == (qfa_pkg::Q_AW+1)'(qfa_pkg::Q_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: sv/qfa_back.sv
module qfa_back (
	input  logic               clk,
	input  logic               arst_n,
	input  qfa_pkg::item_t     q_item,
	input  logic               q_empty,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result,
	output logic               flag,
	output logic               divide_by_zero
);

	localparam int N = qfa_pkg::DIV_STEPS;

	logic                  adv;
	logic                  v_s1;
	qfa_pkg::item_t        it_s1;
	logic signed [63:0]    prod_s1;
	logic                  v_sn  [1:N];
	qfa_pkg::stage_t       st_sn [1:N];
	qfa_pkg::stage_t       first;
	qfa_pkg::stage_t       last;
	logic [31:0]           q_low;

	// Advance everything unless the finished beat is held.
	assign adv   = !(v_sn[N] && out_stall);
	assign q_pop = adv && !q_empty;

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s1   <= q_item;
			prod_s1 <= $signed(q_item.lhs) * $signed(q_item.rhs);
		end
	end

	always_comb begin
		first        = '0;
		first.is_div = (it_s1.op == qfa_pkg::OP_DIV);
		first.q_neg  = it_s1.q_neg;
		first.dz     = first.is_div && it_s1.dz;
		first.num    = it_s1.num_mag;
		first.den    = it_s1.den_mag;
		case (it_s1.op)
			qfa_pkg::OP_ADD:   first.res = it_s1.lhs + it_s1.rhs;
			qfa_pkg::OP_SUB:   first.res = it_s1.lhs - it_s1.rhs;
			qfa_pkg::OP_MUL:   first.res = prod_s1[qfa_pkg::FRAC_BITS +: 32];
			qfa_pkg::OP_EQ:    first.flag = (it_s1.lhs == it_s1.rhs);
			qfa_pkg::OP_LT:    first.flag = ($signed(it_s1.lhs) < $signed(it_s1.rhs));
			qfa_pkg::OP_FLOOR: first.res = $signed(it_s1.lhs) >>> qfa_pkg::FRAC_BITS;
			qfa_pkg::OP_FRAC:  first.res = 32'(it_s1.lhs[qfa_pkg::FRAC_BITS-1:0]);
			default:           first.res = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_sn[1] <= qfa_pkg::div_step(first);
		end
	end

	for (genvar k = 2; k <= N; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (adv) begin
				st_sn[k] <= qfa_pkg::div_step(st_sn[k-1]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int i = 1; i <= N; i++) begin
				v_sn[i] <= 1'b0;
			end
		end else if (adv) begin
			v_s1    <= !q_empty;
			v_sn[1] <= v_s1;
			for (int i = 2; i <= N; i++) begin
				v_sn[i] <= v_sn[i-1];
			end
		end
	end

	always_comb begin
		last  = st_sn[N];
		q_low = last.num[31:0];
		if (last.is_div) begin
			if (last.dz) begin
				result = '0;
			end else if (last.q_neg) begin
				result = ~q_low + 32'd1;
			end else begin
				result = q_low;
			end
		end else begin
			result = last.res;
		end
		flag           = last.flag;
		divide_by_zero = last.dz;
		out_valid      = v_sn[N];
	end

endmodule

FILE: sv/q16_16_fixed_point_alu.sv
// Signed Q16.16 arithmetic unit.
// Input channel: in_valid / in_stall with kind, lhs, rhs. A beat is taken
// at a rising edge of clk with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with result, flag, divide_by_zero.
// Every input beat gives exactly one output beat, in order.
// Kinds: add, sub (wrapping), mul (product >>> 16, low 32 bits), div
// (dividend << 16, truncated toward zero; zero divisor gives 0 and
// divide_by_zero), equals and signed compare (flag only), floor, frac.
// A front stage classifies each beat into a 4-entry queue; the back end is
// one entry register plus a 48-stage restoring divider pipeline, one
// quotient bit per stage, that every kind passes through.
// Each beat passes through the queue, the entry register and the 48
// divider stages in turn; the divider pipeline sets the latency.
// Throughput: one beat per cycle while the output is not stalled.
// A held output beat freezes the back end; the queue keeps taking beats
// until full, then in_stall rises.
// Reset (arst_n low) empties the queue and clears all valid bits.
module q16_16_fixed_point_alu (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         kind,
	input  logic signed [31:0] lhs,
	input  logic signed [31:0] rhs,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result,
	output logic               flag,
	output logic               divide_by_zero
);

	`include "q16_16_fixed_point_alu_assert.svh"

	qfa_pkg::item_t item;
	qfa_pkg::item_t q_item;
	logic           q_full;
	logic           q_empty;
	logic           q_pop;
	logic           push;

	// Classify the incoming beat.
	qfa_front u_front (
		.kind (kind),
		.lhs  (lhs),
		.rhs  (rhs),
		.item (item)
	);

	// Take a beat whenever the queue has room.
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	qfa_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (item),
		.full    (q_full),
		.pop     (q_pop),
		.rd_item (q_item),
		.empty   (q_empty)
	);

	// Execute; hold everything while the output beat is stalled.
	qfa_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_item         (q_item),
		.q_empty        (q_empty),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result         (result),
		.flag           (flag),
		.divide_by_zero (divide_by_zero)
	);

	`QFA_ASSERT_IMP(a_dz_zero, out_valid && divide_by_zero, (result == 32'sd0) && !flag, "divide by zero beat must carry zero result")
	`QFA_ASSERT_IMP(a_flag_zero, out_valid && flag, (result == 32'sd0) && !divide_by_zero, "compare beat must carry zero result")
	`QFA_ASSERT_IMP(a_pop_held, out_valid && out_stall, !q_pop, "queue popped while output held")
	`QFA_ASSERT_NXT(a_hold_stable, out_valid && out_stall, out_valid && $stable(result), "held output beat changed")

endmodule

FILE: tb/tb_q16_16_fixed_point_alu.sv
`timescale 1ns / 1ps

module tb_q16_16_fixed_point_alu;

	localparam int LATENCY = 50;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         kind;
	logic signed [31:0] lhs;
	logic signed [31:0] rhs;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] result;
	logic               flag;
	logic               divide_by_zero;

	// One expected output beat.
	typedef struct {
		logic [31:0] res;
		logic        flg;
		logic        dz;
	} alu_out_t;

	alu_out_t answers_q[$];
	int       mismatch_cnt;
	int       send_idle_pct;
	int       recv_stall_pct;

	q16_16_fixed_point_alu dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.lhs            (lhs),
		.rhs            (rhs),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result         (result),
		.flag           (flag),
		.divide_by_zero (divide_by_zero)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Compute what the unit should produce for one operation.
	function automatic alu_out_t compute_q16(qfa_pkg::op_t op, logic signed [31:0] a,
			logic signed [31:0] b);
		alu_out_t           o;
		logic signed [63:0] prod;
		logic signed [63:0] num;
		logic signed [63:0] quo;
		o.res = '0;
		o.flg = 1'b0;
		o.dz  = 1'b0;
		case (op)
			qfa_pkg::OP_ADD: o.res = a + b;
			qfa_pkg::OP_SUB: o.res = a - b;
			qfa_pkg::OP_MUL: begin
				prod  = 64'(a) * 64'(b);
				o.res = 32'(prod >>> qfa_pkg::FRAC_BITS);
			end
			qfa_pkg::OP_DIV: begin
				if (b == 0) begin
					o.dz = 1'b1;
				end else begin
					// SV signed divide truncates toward zero
					num   = 64'(a) <<< qfa_pkg::FRAC_BITS;
					quo   = num / 64'(b);
					o.res = 32'(quo);
				end
			end
			qfa_pkg::OP_EQ: o.flg = (a == b);
			qfa_pkg::OP_LT: o.flg = (a < b);
			qfa_pkg::OP_FLOOR: o.res = 32'(a >>> qfa_pkg::FRAC_BITS);
			default: o.res = {16'd0, a[15:0]};
		endcase
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("t=%0t %s: got %h, want %h", $time, what, got, want);
		mismatch_cnt++;
	endtask

	// Send one beat; idle at random first, then hold until accepted.
	task automatic send_beat(qfa_pkg::op_t op, logic [31:0] a, logic [31:0] b);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind     <= op;
		lhs      <= a;
		rhs      <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		answers_q.push_back(compute_q16(op, a, b));
	endtask

	// Receiver: random stall, check each accepted beat against the oldest answer.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (answers_q.size() == 0) begin
					report_mismatch("unexpected beat", result, 32'd0);
				end else begin
					alu_out_t w;
					w = answers_q.pop_front();
					if (result !== w.res) report_mismatch("result", result, w.res);
					if (flag !== w.flg) report_mismatch("flag", flag, w.flg);
					if (divide_by_zero !== w.dz)
						report_mismatch("divide_by_zero", divide_by_zero, w.dz);
				end
			end
			out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Operand with a bias toward edge values.
	function automatic logic [31:0] pick_operand();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'h0001_0000;
			4: return 32'hffff_0000;
			5: return 32'(signed'(16'($urandom)));
			6: return {16'($urandom_range(3)), 16'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	// Drop valid and hold until every expected beat has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (answers_q.size() != 0) @(posedge clk);
	endtask

	task automatic test_extremes();
		send_beat(qfa_pkg::OP_ADD, 32'h7fff_ffff, 32'h0000_0001);
		send_beat(qfa_pkg::OP_SUB, 32'h8000_0000, 32'h0000_0001);
		send_beat(qfa_pkg::OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
		send_beat(qfa_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
		send_beat(qfa_pkg::OP_MUL, 32'hffff_0000, 32'h0002_8000);
		send_beat(qfa_pkg::OP_DIV, 32'h0001_0000, 32'h0000_0000);
		send_beat(qfa_pkg::OP_DIV, 32'h8000_0000, 32'h0000_0000);
		send_beat(qfa_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ffff);
		send_beat(qfa_pkg::OP_DIV, 32'h7fff_ffff, 32'h0000_0001);
		send_beat(qfa_pkg::OP_DIV, 32'hfffe_0000, 32'h0003_0000);
		send_beat(qfa_pkg::OP_DIV, 32'h0007_0000, 32'hfffe_0000);
		send_beat(qfa_pkg::OP_EQ, 32'h1234_5678, 32'h1234_5678);
		send_beat(qfa_pkg::OP_EQ, 32'h1234_5678, 32'h1234_5679);
		send_beat(qfa_pkg::OP_LT, 32'h8000_0000, 32'h7fff_ffff);
		send_beat(qfa_pkg::OP_LT, 32'h7fff_ffff, 32'h8000_0000);
		send_beat(qfa_pkg::OP_LT, 32'h0000_0005, 32'h0000_0005);
		send_beat(qfa_pkg::OP_FLOOR, 32'hfffe_8000, 32'hffff_ffff);
		send_beat(qfa_pkg::OP_FLOOR, 32'h7fff_ffff, 32'h0000_0000);
		send_beat(qfa_pkg::OP_FRAC, 32'hffff_ffff, 32'hffff_ffff);
		send_beat(qfa_pkg::OP_FRAC, 32'h8000_0000, 32'h0000_0000);
	endtask

	task automatic test_random(int count, int idle_pct, int stall_pct);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count)
			send_beat(qfa_pkg::op_t'($urandom_range(7)), pick_operand(), pick_operand());
	endtask

	// Hold off the sender until the pipeline drains, then send LATENCY beats.
	task automatic test_pause_until_drained();
		wait_drained();
		repeat (LATENCY)
			send_beat(qfa_pkg::op_t'($urandom_range(7)), $urandom, $urandom);
	endtask

	initial begin
		mismatch_cnt   = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		kind      = '0;
		lhs       = '0;
		rhs       = '0;
		out_stall = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_random(260, 0, 0);
		test_random(260, 46, 0);
		test_pause_until_drained();
		test_random(260, 0, 46);
		test_random(260, 22, 22);
		test_random(60, 0, 0);
		wait_drained();
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatch_cnt == 0 && answers_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
